// File: design/hrmd_pkg.sv
package hrmd_pkg;

  // Field widths
  localparam int unsigned WordW  = 36;
  localparam int unsigned KindW  = 3;
  localparam int unsigned PortW  = 8;
  localparam int unsigned CodeW  = 6;
  localparam int unsigned ValW   = 16;
  localparam int unsigned LinesW = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned CharW  = 7;

  // Results one ring word can cause, and the count/index widths for them
  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResCntW = 3;
  localparam int unsigned ResIdxW = 2;

  // Line count ceiling
  localparam int unsigned LineMax = 32;

  // Result kinds
  localparam logic [KindW-1:0] KIND_CHAR    = 3'd0;
  localparam logic [KindW-1:0] KIND_CMD     = 3'd1;
  localparam logic [KindW-1:0] KIND_ORANGE  = 3'd2;
  localparam logic [KindW-1:0] KIND_HOST    = 3'd3;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 3'd4;

  // Header type codes
  localparam int unsigned    TYPE_DATA_BIT = 7;
  localparam logic [7:0]     TYPE_FIRST    = 8'o001;
  localparam logic [7:0]     TYPE_YELLOW   = 8'o020;
  localparam logic [7:0]     TYPE_HOSTINFO = 8'o041;

  // Header field positions
  localparam int unsigned TYPE_POS = 28;
  localparam int unsigned PORT_POS = 20;
  localparam int unsigned SUB_POS  = 12;
  localparam int unsigned DAT_POS  = 4;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [PortW-1:0]  port_number;
    logic [CodeW-1:0]  command_code;
    logic [ValW-1:0]   char_or_host;
    logic [LinesW-1:0] line_count;
  } result_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [ResCntW-1:0]   cnt;
  } bundle_t;

  typedef struct packed {
    logic [CountW-1:0] chars_remaining;
    logic [PortW-1:0]  current_port;
    logic [ValW-1:0]   host_number;
    logic [LinesW-1:0] active_lines;
  } state_t;

endpackage

// File: design/hrmd_if.sv
// Ring word channel
interface hrmd_in_if;
  logic                           valid;
  logic                           ready;
  logic [hrmd_pkg::WordW-1:0]     ring_word;

  modport source (output valid, output ring_word, input ready);
  modport sink   (input valid, input ring_word, output ready);
endinterface

// Result channel
interface hrmd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hrmd_pkg::KindW-1:0]     kind;
  logic [hrmd_pkg::PortW-1:0]     port_number;
  logic [hrmd_pkg::CodeW-1:0]     command_code;
  logic [hrmd_pkg::ValW-1:0]      char_or_host;
  logic [hrmd_pkg::LinesW-1:0]    line_count;
  logic                           last_result;

  modport source (output valid, output kind, output port_number, output command_code,
                  output char_or_host, output line_count, output last_result,
                  input ready);
  modport sink   (input valid, input kind, input port_number, input command_code,
                  input char_or_host, input line_count, input last_result,
                  output ready);
endinterface

// File: design/hrmd_decode.sv
module hrmd_decode (
  input  logic [hrmd_pkg::WordW-1:0] word_i,
  input  hrmd_pkg::state_t           state_i,
  output hrmd_pkg::bundle_t          bundle_o,
  output hrmd_pkg::state_t           state_o
);

  logic [7:0] f_type;
  logic [7:0] f_port;
  logic [7:0] f_sub;
  logic [7:0] f_dat;
  logic [hrmd_pkg::CountW-1:0] n_chars;

  assign f_type  = word_i[hrmd_pkg::TYPE_POS +: 8];
  assign f_port  = word_i[hrmd_pkg::PORT_POS +: 8];
  assign f_sub   = word_i[hrmd_pkg::SUB_POS +: 8];
  assign f_dat   = word_i[hrmd_pkg::DAT_POS +: 8];
  assign n_chars = f_type[hrmd_pkg::CountW-1:0];

  // Split one word into its results and the state it leaves
  always_comb begin
    bundle_o = '0;
    state_o  = state_i;
    if (state_i.chars_remaining != '0) begin
      // Continuation word: up to four characters, whatever the bits
      for (int i = 0; i < hrmd_pkg::MaxRes; i++) begin
        bundle_o.res[i].kind         = hrmd_pkg::KIND_CHAR;
        bundle_o.res[i].port_number  = state_i.current_port;
        bundle_o.res[i].char_or_host =
          hrmd_pkg::ValW'(word_i[(hrmd_pkg::TYPE_POS - 8 * i) +: hrmd_pkg::CharW]);
      end
      if (state_i.chars_remaining >= hrmd_pkg::CountW'(hrmd_pkg::MaxRes)) begin
        bundle_o.cnt = hrmd_pkg::ResCntW'(hrmd_pkg::MaxRes);
      end else begin
        bundle_o.cnt = state_i.chars_remaining[hrmd_pkg::ResCntW-1:0];
      end
      state_o.chars_remaining =
        state_i.chars_remaining - hrmd_pkg::CountW'(bundle_o.cnt);
    end else if (f_type[hrmd_pkg::TYPE_DATA_BIT]) begin
      // Data header: first two characters ride in subtype and data
      state_o.current_port = f_port;
      bundle_o.res[0].kind         = hrmd_pkg::KIND_CHAR;
      bundle_o.res[0].port_number  = f_port;
      bundle_o.res[0].char_or_host = hrmd_pkg::ValW'(f_sub[hrmd_pkg::CharW-1:0]);
      bundle_o.res[1].kind         = hrmd_pkg::KIND_CHAR;
      bundle_o.res[1].port_number  = f_port;
      bundle_o.res[1].char_or_host = hrmd_pkg::ValW'(f_dat[hrmd_pkg::CharW-1:0]);
      if (n_chars >= hrmd_pkg::CountW'(2)) begin
        bundle_o.cnt            = hrmd_pkg::ResCntW'(2);
        state_o.chars_remaining = n_chars - hrmd_pkg::CountW'(2);
      end else begin
        bundle_o.cnt            = hrmd_pkg::ResCntW'(n_chars[0]);
        state_o.chars_remaining = '0;
      end
    end else if (f_type >= hrmd_pkg::TYPE_FIRST && f_type <= hrmd_pkg::TYPE_HOSTINFO) begin
      // Control message: command result, plus orange or host info
      bundle_o.res[0].kind         = hrmd_pkg::KIND_CMD;
      bundle_o.res[0].port_number  = f_port;
      bundle_o.res[0].command_code = f_type[hrmd_pkg::CodeW-1:0];
      bundle_o.cnt                 = hrmd_pkg::ResCntW'(1);
      if (f_type == hrmd_pkg::TYPE_YELLOW) begin
        bundle_o.res[1].kind        = hrmd_pkg::KIND_ORANGE;
        bundle_o.res[1].port_number = f_port;
        bundle_o.cnt                = hrmd_pkg::ResCntW'(2);
      end
      if (f_type == hrmd_pkg::TYPE_HOSTINFO) begin
        state_o.host_number = {f_sub, f_dat};
        if (f_port > hrmd_pkg::PortW'(hrmd_pkg::LineMax)) begin
          state_o.active_lines = hrmd_pkg::LinesW'(hrmd_pkg::LineMax);
        end else begin
          state_o.active_lines = f_port[hrmd_pkg::LinesW-1:0];
        end
        bundle_o.res[1].kind         = hrmd_pkg::KIND_HOST;
        bundle_o.res[1].char_or_host = state_o.host_number;
        bundle_o.res[1].line_count   = state_o.active_lines;
        bundle_o.cnt                 = hrmd_pkg::ResCntW'(2);
      end
    end else begin
      // Unknown type: consume with an error result
      bundle_o.res[0].kind        = hrmd_pkg::KIND_UNKNOWN;
      bundle_o.res[0].port_number = f_port;
      bundle_o.cnt                = hrmd_pkg::ResCntW'(1);
    end
  end

endmodule

// File: design/host_ring_message_deframer_core.sv
// Host ring message deframer. Ring words enter on in_i and are split into result
// items on out_o, one result item per cycle while out_o is ready. A word is held
// in an input register, decoded combinationally into all of its results (up to
// four), and the results then leave from a result register one per cycle while
// out_o is ready. A command or a short header gives one result, yellow,
// host-info and data headers two, and a continuation word up to four. The
// result register's single output port is why a word's results leave one at
// a time. A data header with a character count of zero gives no result. While
// results wait on out_o the next word is still taken into the input register.
module host_ring_message_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrmd_in_if.sink    in_i,
  hrmd_out_if.source out_o
);

  logic                              in_valid_q;
  logic [hrmd_pkg::WordW-1:0]        in_word_q;
  logic                              bun_valid_q;
  hrmd_pkg::bundle_t                 bun_q;
  logic [hrmd_pkg::ResIdxW-1:0]      idx_q;
  hrmd_pkg::state_t                  st_q;
  hrmd_pkg::state_t                  st_d;
  hrmd_pkg::bundle_t                 dec_bundle;
  hrmd_pkg::result_t                 cur_res;

  logic out_fire;
  logic bun_last;
  logic bun_free;
  logic advance;

  hrmd_decode u_decode (
    .word_i   (in_word_q),
    .state_i  (st_q),
    .bundle_o (dec_bundle),
    .state_o  (st_d)
  );

  // Handshake control
  assign out_fire   = out_o.valid & out_o.ready;
  assign bun_last   = ({1'b0, idx_q} == (bun_q.cnt - hrmd_pkg::ResCntW'(1)));
  assign bun_free   = !bun_valid_q || (out_fire && bun_last);
  assign advance    = in_valid_q && bun_free;
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_word_q <= in_i.ring_word;
    end
  end

  // Message state: advance when a word is decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.chars_remaining <= '0;
      st_q.current_port    <= '0;
      st_q.host_number     <= '0;
      st_q.active_lines    <= hrmd_pkg::LinesW'(hrmd_pkg::LineMax);
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register: load a decoded word, step through its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      bun_valid_q <= (dec_bundle.cnt != '0);
      idx_q       <= '0;
    end else if (out_fire) begin
      if (bun_last) begin
        bun_valid_q <= 1'b0;
      end
      idx_q <= idx_q + hrmd_pkg::ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bun_q <= dec_bundle;
    end
  end

  // Drive the result channel
  assign cur_res            = bun_q.res[idx_q];
  assign out_o.valid        = bun_valid_q;
  assign out_o.kind         = cur_res.kind;
  assign out_o.port_number  = cur_res.port_number;
  assign out_o.command_code = cur_res.command_code;
  assign out_o.char_or_host = cur_res.char_or_host;
  assign out_o.line_count   = cur_res.line_count;
  assign out_o.last_result  = bun_last;

endmodule

// File: design/hrmd_checker.sv
module hrmd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [hrmd_pkg::KindW-1:0]     kind_i,
  input logic [hrmd_pkg::PortW-1:0]     port_number_i,
  input logic [hrmd_pkg::CodeW-1:0]     command_code_i,
  input logic [hrmd_pkg::LinesW-1:0]    line_count_i,
  input logic                           last_result_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i)
      && $stable(port_number_i) && $stable(last_result_i))
    else $error("result changed while stalled");

  // Host info carries no port and a clamped line count
  a_host_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == hrmd_pkg::KIND_HOST |->
      port_number_i == '0 && line_count_i <= hrmd_pkg::LinesW'(hrmd_pkg::LineMax)
      && last_result_i)
    else $error("bad host info result");

  // Yellow and host-info commands are followed by a second result
  a_cmd_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == hrmd_pkg::KIND_CMD
      && (command_code_i == hrmd_pkg::CodeW'(hrmd_pkg::TYPE_YELLOW)
          || command_code_i == hrmd_pkg::CodeW'(hrmd_pkg::TYPE_HOSTINFO))
      |-> !last_result_i)
    else $error("command lost its follow-up result");

  // Unknown types and orange replies end their word
  a_single_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == hrmd_pkg::KIND_UNKNOWN || kind_i == hrmd_pkg::KIND_ORANGE)
      |-> last_result_i && command_code_i == '0)
    else $error("unknown or orange result not last");

endmodule

bind host_ring_message_deframer_core hrmd_checker u_hrmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .port_number_i  (out_o.port_number),
  .command_code_i (out_o.command_code),
  .line_count_i   (out_o.line_count),
  .last_result_i  (out_o.last_result)
);

// File: dv/tb_host_ring_message_deframer_core.sv
module tb_host_ring_message_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Header type codes used by the stimulus
  localparam logic [7:0] TypeNone       = 8'o000;
  localparam logic [7:0] TypeCmdMid     = 8'o013;
  localparam logic [7:0] TypeZap        = 8'o021;
  localparam logic [7:0] TypeCtrlPast   = 8'o040;
  localparam logic [7:0] TypeUnknownLo  = 8'o042;
  localparam logic [7:0] TypeUnknownHi  = 8'o177;
  localparam int unsigned CharsPerWord  = 4;
  localparam int unsigned MaxCount      = 127;

  // Run control
  localparam int unsigned RandomWords   = 310;
  localparam int unsigned StreamWords   = 40;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainLimit    = 20000;
  localparam int unsigned MaxPrinted    = 30;

  typedef struct {
    logic [hrmd_pkg::KindW-1:0]  kind;
    logic [hrmd_pkg::PortW-1:0]  port_number;
    logic [hrmd_pkg::CodeW-1:0]  command_code;
    logic [hrmd_pkg::ValW-1:0]   char_or_host;
    logic [hrmd_pkg::LinesW-1:0] line_count;
    logic                        last_result;
  } deframed_t;

  logic clk_i;
  logic rst_ni;

  hrmd_in_if  ring_ch ();
  hrmd_out_if res_ch ();

  host_ring_message_deframer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ring_ch),
    .out_o  (res_ch)
  );

  // Deframer state as predicted
  logic [hrmd_pkg::CountW-1:0] msg_chars_left = '0;
  logic [hrmd_pkg::PortW-1:0]  msg_port       = '0;
  logic [hrmd_pkg::ValW-1:0]   host_id        = '0;
  logic [hrmd_pkg::LinesW-1:0] lines_up       = hrmd_pkg::LinesW'(hrmd_pkg::LineMax);

  deframed_t pending_results[$];

  int unsigned err_count    = 0;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned rx_hold      = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MaxPrinted) $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  function automatic deframed_t make_result(input logic [hrmd_pkg::KindW-1:0] kind,
                                            input logic [hrmd_pkg::PortW-1:0] port,
                                            input logic [hrmd_pkg::CodeW-1:0] code,
                                            input logic [hrmd_pkg::ValW-1:0] val,
                                            input logic [hrmd_pkg::LinesW-1:0] lines);
    deframed_t r;
    r.kind         = kind;
    r.port_number  = port;
    r.command_code = code;
    r.char_or_host = val;
    r.line_count   = lines;
    r.last_result  = 1'b0;
    return r;
  endfunction

  // Split one ring word into its expected results and advance the state
  function automatic void deframe_word(input logic [hrmd_pkg::WordW-1:0] w);
    logic [7:0] typ;
    logic [7:0] prt;
    logic [7:0] sub;
    logic [7:0] dat;
    logic [hrmd_pkg::CountW-1:0] count;
    deframed_t batch[$];
    int i;
    typ   = w[hrmd_pkg::TYPE_POS +: 8];
    prt   = w[hrmd_pkg::PORT_POS +: 8];
    sub   = w[hrmd_pkg::SUB_POS +: 8];
    dat   = w[hrmd_pkg::DAT_POS +: 8];
    count = typ[hrmd_pkg::CountW-1:0];
    if (msg_chars_left != 0) begin
      // continuation word: data whatever its bits say
      for (i = 0; i < CharsPerWord && msg_chars_left != 0; i++) begin
        batch.push_back(make_result(hrmd_pkg::KIND_CHAR, msg_port, '0,
          hrmd_pkg::ValW'(w[int'(hrmd_pkg::TYPE_POS) - 8 * i +: hrmd_pkg::CharW]), '0));
        msg_chars_left--;
      end
    end else if (typ[hrmd_pkg::TYPE_DATA_BIT]) begin
      msg_port = prt;
      if (count >= 1)
        batch.push_back(make_result(hrmd_pkg::KIND_CHAR, prt, '0,
                                    hrmd_pkg::ValW'(sub[hrmd_pkg::CharW-1:0]), '0));
      if (count >= 2)
        batch.push_back(make_result(hrmd_pkg::KIND_CHAR, prt, '0,
                                    hrmd_pkg::ValW'(dat[hrmd_pkg::CharW-1:0]), '0));
      msg_chars_left = (count >= 2) ? count - hrmd_pkg::CountW'(2) : '0;
    end else if (typ >= hrmd_pkg::TYPE_FIRST && typ <= hrmd_pkg::TYPE_HOSTINFO) begin
      batch.push_back(make_result(hrmd_pkg::KIND_CMD, prt, typ[hrmd_pkg::CodeW-1:0],
                                  '0, '0));
      if (typ == hrmd_pkg::TYPE_YELLOW)
        batch.push_back(make_result(hrmd_pkg::KIND_ORANGE, prt, '0, '0, '0));
      if (typ == hrmd_pkg::TYPE_HOSTINFO) begin
        host_id  = {sub, dat};
        lines_up = (prt > hrmd_pkg::LineMax) ? hrmd_pkg::LinesW'(hrmd_pkg::LineMax)
                                             : prt[hrmd_pkg::LinesW-1:0];
        batch.push_back(make_result(hrmd_pkg::KIND_HOST, '0, '0, host_id, lines_up));
      end
    end else begin
      batch.push_back(make_result(hrmd_pkg::KIND_UNKNOWN, prt, '0, '0, '0));
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_result = 1'b1;
    foreach (batch[j]) pending_results.push_back(batch[j]);
  endfunction

  function automatic logic [hrmd_pkg::WordW-1:0] random_word();
    return {4'($urandom_range(0, 15)), 32'($urandom)};
  endfunction

  function automatic logic [hrmd_pkg::WordW-1:0] header(input logic [7:0] typ,
                                                        input logic [7:0] prt,
                                                        input logic [7:0] sub,
                                                        input logic [7:0] dat);
    return {typ, prt, sub, dat, 4'($urandom_range(0, 15))};
  endfunction

  // Offer one word, with an optional idle burst ahead of it, and hold until taken
  task automatic offer_ring_item(input logic [hrmd_pkg::WordW-1:0] w);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      ring_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    ring_ch.valid     <= 1'b1;
    ring_ch.ring_word <= w;
    @(posedge clk_i);
    while (!ring_ch.ready) @(posedge clk_i);
    deframe_word(w);
    words_sent++;
  endtask

  // Stop sending until every predicted result has come out, then settle
  task automatic wait_all_delivered();
    int unsigned spins;
    spins = 0;
    ring_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && spins < DrainLimit) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_data_message(input int unsigned count, input logic [7:0] prt);
    int unsigned cont;
    cont = (count > 2) ? (count - 2 + CharsPerWord - 1) / CharsPerWord : 0;
    offer_ring_item(header({1'b1, 7'(count)}, prt, 8'($urandom), 8'($urandom)));
    repeat (cont) offer_ring_item(random_word());
  endtask

  task automatic send_random_message();
    int unsigned pick;
    logic [7:0] prt;
    pick = $urandom_range(0, 99);
    prt  = $urandom_range(0, 1) ? 8'($urandom_range(0, 40)) : 8'($urandom);
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) send_data_message($urandom_range(13, MaxCount), prt);
      else send_data_message($urandom_range(0, 12), prt);
    end else if (pick < 88) begin
      offer_ring_item(header(8'($urandom_range(hrmd_pkg::TYPE_FIRST,
                                               hrmd_pkg::TYPE_HOSTINFO)),
                             prt, 8'($urandom), 8'($urandom)));
    end else begin
      offer_ring_item(header($urandom_range(0, 3) == 0 ? TypeNone :
                             8'($urandom_range(TypeUnknownLo, TypeUnknownHi)),
                             prt, 8'($urandom), 8'($urandom)));
    end
  endtask

  // Commands, orange reply, host info with line clamp, unknown types
  task automatic test_control_messages();
    offer_ring_item('0);
    offer_ring_item(header(hrmd_pkg::TYPE_FIRST, 8'hFF, 8'h00, 8'h00));
    offer_ring_item(header(hrmd_pkg::TYPE_YELLOW, 8'hA5, 8'h5A, 8'hC3));
    offer_ring_item(header(TypeZap, 8'h3C, 8'hFF, 8'hFF));
    offer_ring_item(header(TypeCmdMid, 8'h01, 8'h80, 8'h01));
    offer_ring_item(header(TypeCtrlPast, 8'h80, 8'h7F, 8'hFE));
    offer_ring_item(header(hrmd_pkg::TYPE_HOSTINFO, 8'd200, 8'hFF, 8'hFF));
    offer_ring_item(header(hrmd_pkg::TYPE_HOSTINFO, 8'd32, 8'h12, 8'h34));
    offer_ring_item(header(hrmd_pkg::TYPE_HOSTINFO, 8'd0, 8'h00, 8'h00));
    offer_ring_item(header(hrmd_pkg::TYPE_HOSTINFO, 8'd33, 8'hAB, 8'hCD));
    offer_ring_item(header(TypeUnknownLo, 8'h77, 8'h11, 8'h22));
    offer_ring_item({TypeUnknownHi, 28'hFFF_FFFF});
    wait_all_delivered();
  endtask

  // Empty, short and multi-word data messages; continuation that looks like a header
  task automatic test_data_framing();
    offer_ring_item(header(8'h80, 8'h11, 8'h7F, 8'h7F));
    offer_ring_item(header(8'h81, 8'hFE, 8'hFF, 8'h55));
    offer_ring_item(header(8'h82, 8'h01, 8'h80, 8'h00));
    offer_ring_item(header(8'h83, 8'h42, 8'h41, 8'h42));
    offer_ring_item({8'hC3, 28'h000_0000});
    offer_ring_item(header(8'h86, 8'h07, 8'h48, 8'h49));
    offer_ring_item(header(hrmd_pkg::TYPE_HOSTINFO, 8'h10, 8'h99, 8'h99));
    offer_ring_item(header(8'h8A, 8'hFF, 8'h2A, 8'hAA));
    offer_ring_item({hrmd_pkg::WordW{1'b1}});
    offer_ring_item('0);
    // once the message is used up, the next word is a header again
    offer_ring_item(header(hrmd_pkg::TYPE_YELLOW, 8'h00, 8'h00, 8'h00));
    wait_all_delivered();
  endtask

  // Header of all ones opens the longest message
  task automatic test_longest_message();
    offer_ring_item({hrmd_pkg::WordW{1'b1}});
    repeat ((MaxCount - 2 + CharsPerWord - 1) / CharsPerWord)
      offer_ring_item(random_word());
    wait_all_delivered();
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    first = words_sent;
    while (words_sent - first < RandomWords) begin
      send_random_message();
      if ($urandom_range(0, 39) == 0) wait_all_delivered();
    end
    wait_all_delivered();
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    int unsigned first;
    first      = words_sent;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (words_sent - first < StreamWords) send_random_message();
    wait_all_delivered();
  endtask

  // Result ready with random stall bursts; held low through reset
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      res_ch.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(1, 19) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [hrmd_pkg::ValW-1:0] got,
                             input logic [hrmd_pkg::ValW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  // Compare each result against the oldest prediction
  always @(posedge clk_i) begin
    deframed_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with none pending: kind %0d port %0h",
                                  results_seen, res_ch.kind, res_ch.port_number));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", hrmd_pkg::ValW'(res_ch.kind), hrmd_pkg::ValW'(want.kind));
        check_field("port_number", hrmd_pkg::ValW'(res_ch.port_number),
                    hrmd_pkg::ValW'(want.port_number));
        check_field("command_code", hrmd_pkg::ValW'(res_ch.command_code),
                    hrmd_pkg::ValW'(want.command_code));
        check_field("char_or_host", res_ch.char_or_host, want.char_or_host);
        check_field("line_count", hrmd_pkg::ValW'(res_ch.line_count),
                    hrmd_pkg::ValW'(want.line_count));
        check_field("last_result", hrmd_pkg::ValW'(res_ch.last_result),
                    hrmd_pkg::ValW'(want.last_result));
      end
      results_seen++;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    ring_ch.valid     = 1'b0;
    ring_ch.ring_word = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_control_messages();
    test_data_framing();
    test_longest_message();
    test_random_traffic();
    test_back_to_back();

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never came out",
                                pending_results.size()));
    $display("Sent %0d ring words: commands, orange, host info, unknown types,", words_sent);
    $display("empty to 127-character messages, random and full-rate traffic; %0d results",
             results_seen);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
